[hw/rtl/cds_pkg.sv]
// Shared types, constants and calendar functions for the calendar date stepper.
// Used by the channel interfaces, the day step unit and the top level.
`default_nettype none

package cds_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int CNT_W   = 16;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

    // Request kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_NEXT = 2'd1;
    localparam logic [1:0] KIND_PREV = 2'd2;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        date_t date;
        logic  ok;
    } step_res_t;

    // Leap year: divisible by 4 and not by 100, or divisible by 400.
    // y/100 is found as (y/4)/25 through a reciprocal multiply (exact below 4096).
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [11:0] k;
        logic [22:0] prod;
        logic [7:0]  q;
        logic [12:0] q25;
        logic        d4;
        logic        d100;
        k    = y[13:2];
        prod = 23'(k) * 23'd1311;
        q    = prod[22:15];
        q25  = {1'b0, q, 4'b0} + {2'b0, q, 3'b0} + {5'b0, q};
        d4   = (y[1:0] == 2'b00);
        d100 = d4 && ({1'b0, k} == q25);
        return (d4 && !d100) || (d100 && (q[1:0] == 2'b00));
    endfunction

    // Month length, zero for a month code outside 1..12.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cds_req_if.sv]
// Request channel of the calendar date stepper: valid/ready plus load fields.
// Depends on cds_pkg for field widths.
`default_nettype none

interface cds_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [cds_pkg::YEAR_W-1:0]  load_year;
    logic [6:0]                  load_month;
    logic [6:0]                  load_day;

    modport source (output valid, kind, load_year, load_month, load_day, input ready);
    modport sink   (input valid, kind, load_year, load_month, load_day, output ready);
endinterface

`default_nettype wire

[hw/rtl/cds_rsp_if.sv]
// Result channel of the calendar date stepper: valid/ready plus date fields.
// Depends on cds_pkg for field widths.
`default_nettype none

interface cds_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [cds_pkg::YEAR_W-1:0]   year;
    logic [cds_pkg::MONTH_W-1:0]  month;
    logic [cds_pkg::DAY_W-1:0]    day;
    logic [cds_pkg::YEAR_W-1:0]   target_year;
    logic [cds_pkg::MONTH_W-1:0]  target_month;
    logic [cds_pkg::DAY_W-1:0]    target_day;
    logic                         target_valid;
    logic                         load_error;
    logic                         range_error;

    modport source (output valid, year, month, day, target_year, target_month,
                    target_day, target_valid, load_error, range_error,
                    input ready);
    modport sink   (input valid, year, month, day, target_year, target_month,
                    target_day, target_valid, load_error, range_error,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/cds_step.sv]
// Shared day step unit: moves a date one day forward or back, flags the range ends,
// and reports the length of the given month. Depends on cds_pkg.
`default_nettype none

module cds_step (
    input  wire cds_pkg::date_t                  date_in,
    input  wire                                  back,
    output cds_pkg::step_res_t                   res,
    output logic [cds_pkg::DAY_W-1:0]            mlen
);

    logic                       leap;
    logic [cds_pkg::DAY_W-1:0]  mlen_prev;
    logic [cds_pkg::MONTH_W-1:0] month_prev;

    assign leap       = cds_pkg::is_leap(date_in.year);
    assign mlen       = cds_pkg::month_len(date_in.month, leap);
    assign month_prev = date_in.month - 4'd1;
    assign mlen_prev  = cds_pkg::month_len(month_prev, leap);

    always_comb
    begin
        res.date = date_in;
        res.ok   = 1'b1;
        if (!back)
        begin
            if (date_in.day < mlen)
            begin
                res.date.day = date_in.day + 5'd1;
            end
            else if (date_in.month < 4'd12)
            begin
                res.date.month = date_in.month + 4'd1;
                res.date.day   = 5'd1;
            end
            else if (date_in.year >= cds_pkg::YEAR_MAX)
            begin
                res.ok = 1'b0;
            end
            else
            begin
                res.date.year  = date_in.year + 14'd1;
                res.date.month = 4'd1;
                res.date.day   = 5'd1;
            end
        end
        else
        begin
            if (date_in.day > 5'd1)
            begin
                res.date.day = date_in.day - 5'd1;
            end
            else if (date_in.month > 4'd1)
            begin
                res.date.month = month_prev;
                res.date.day   = mlen_prev;
            end
            else if (date_in.year == 14'd0)
            begin
                res.ok = 1'b0;
            end
            else
            begin
                res.date.year  = date_in.year - 14'd1;
                res.date.month = 4'd12;
                res.date.day   = 5'd31;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/calendar_date_stepper.sv]
// Calendar date stepper top level: sequencer around the shared day step unit.
// Depends on cds_pkg, cds_req_if, cds_rsp_if and cds_step.
`default_nettype none

// Keeps one Gregorian date (reset: Jan 1, 2000) and answers every request
// transaction with one result transaction. A request loads a date (checked for
// year, month and day, with Feb 29 only in leap years), steps the date one day
// forward or back, or (unused kind) leaves it alone. The result carries the new
// current date and a target date day_offset away: a positive offset walks
// offset-1 days ahead, a negative one walks |offset| days back, zero gives no
// target. A walk that would leave years 0..YEAR_MAX stops at the boundary date
// with target_valid low. Steps: S_APPLY applies the request, then S_WALK moves
// the target one day per cycle through the single shared step unit (walk length
// 0 to 32768), and S_DONE puts the result in the output register once it is free.
// The block takes one request at a time; it can accept the next request while the
// previous result still waits in the output register. The user writes day_offset
// through cfg_wr_en/cfg_wr_data while idle; the block itself does not enforce this.
module calendar_date_stepper (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_wr_en,
    input  wire [15:0]           cfg_wr_data,
    cds_req_if.sink              req,
    cds_rsp_if.source            rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_WALK,
        S_DONE
    } state_t;

    state_t                         state_reg;
    logic [15:0]                    offset_reg;

    // Latched request
    logic [1:0]                     kind_reg;
    logic [cds_pkg::YEAR_W-1:0]     ly_reg;
    logic [6:0]                     lm_reg;
    logic [6:0]                     ld_reg;

    cds_pkg::date_t                 cur_reg;
    cds_pkg::date_t                 tgt_reg;
    logic [cds_pkg::CNT_W-1:0]      cnt_reg;
    logic                           back_reg;
    logic                           tvalid_reg;
    logic                           lerr_reg;
    logic                           rerr_reg;

    logic                           out_valid_reg;
    cds_pkg::date_t                 out_cur_reg;
    cds_pkg::date_t                 out_tgt_reg;
    logic                           out_tvalid_reg;
    logic                           out_lerr_reg;
    logic                           out_rerr_reg;

    // Shared step unit and its input select
    cds_pkg::date_t                 unit_in;
    logic                           unit_back;
    cds_pkg::step_res_t             unit_res;
    logic [cds_pkg::DAY_W-1:0]      unit_mlen;

    logic                           load_ok;
    cds_pkg::date_t                 cur_next;
    logic                           rerr_next;
    logic                           lerr_next;
    logic [cds_pkg::CNT_W-1:0]      cnt_next;

    cds_step u_step (
        .date_in (unit_in),
        .back    (unit_back),
        .res     (unit_res),
        .mlen    (unit_mlen)
    );

    assign req.ready = (state_reg == S_IDLE);

    // Feed the unit with the load date, the current date or the walking target
    always_comb
    begin
        if (state_reg == S_WALK)
        begin
            unit_in   = tgt_reg;
            unit_back = back_reg;
        end
        else if (kind_reg == cds_pkg::KIND_LOAD)
        begin
            unit_in.year  = ly_reg;
            unit_in.month = lm_reg[3:0];
            unit_in.day   = 5'd1;
            unit_back     = 1'b0;
        end
        else
        begin
            unit_in   = cur_reg;
            unit_back = (kind_reg == cds_pkg::KIND_PREV);
        end
    end

    // Apply the request to the current date
    always_comb
    begin
        load_ok = (ly_reg <= cds_pkg::YEAR_MAX) && (lm_reg >= 7'd1) && (lm_reg <= 7'd12)
                  && (ld_reg >= 7'd1) && (ld_reg <= {2'b00, unit_mlen});
        cur_next  = cur_reg;
        rerr_next = 1'b0;
        lerr_next = 1'b0;
        case (kind_reg) inside
            cds_pkg::KIND_LOAD:
            begin
                if (load_ok)
                begin
                    cur_next.year  = ly_reg;
                    cur_next.month = lm_reg[3:0];
                    cur_next.day   = ld_reg[4:0];
                end
                else
                begin
                    lerr_next = 1'b1;
                end
            end
            cds_pkg::KIND_NEXT, cds_pkg::KIND_PREV:
            begin
                cur_next  = unit_res.date;
                rerr_next = !unit_res.ok;
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase

        // Walk length: |offset| going back, offset-1 going ahead, zero for none
        if (offset_reg == 16'd0)
        begin
            cnt_next = '0;
        end
        else if (offset_reg[15])
        begin
            cnt_next = (~offset_reg) + 16'd1;
        end
        else
        begin
            cnt_next = offset_reg - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            offset_reg     <= '0;
            kind_reg       <= cds_pkg::KIND_LOAD;
            ly_reg         <= '0;
            lm_reg         <= '0;
            ld_reg         <= '0;
            cur_reg.year   <= 14'd2000;
            cur_reg.month  <= 4'd1;
            cur_reg.day    <= 5'd1;
            tgt_reg        <= '0;
            cnt_reg        <= '0;
            back_reg       <= 1'b0;
            tvalid_reg     <= 1'b0;
            lerr_reg       <= 1'b0;
            rerr_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_cur_reg    <= '0;
            out_tgt_reg    <= '0;
            out_tvalid_reg <= 1'b0;
            out_lerr_reg   <= 1'b0;
            out_rerr_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                offset_reg <= cfg_wr_data;
            end

            // Drop the result once the sink takes it, unless a new one replaces it
            if (out_valid_reg && rsp.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        kind_reg  <= req.kind;
                        ly_reg    <= req.load_year;
                        lm_reg    <= req.load_month;
                        ld_reg    <= req.load_day;
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    cur_reg    <= cur_next;
                    tgt_reg    <= cur_next;
                    lerr_reg   <= lerr_next;
                    rerr_reg   <= rerr_next;
                    cnt_reg    <= cnt_next;
                    back_reg   <= offset_reg[15];
                    tvalid_reg <= (offset_reg != 16'd0);
                    state_reg  <= S_WALK;
                end
                S_WALK:
                begin
                    // Advance the target one day a cycle; stop when the count runs out or at a range end
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (!unit_res.ok)
                    begin
                        tvalid_reg <= 1'b0;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        tgt_reg <= unit_res.date;
                        cnt_reg <= cnt_reg - 16'd1;
                    end
                end
                S_DONE:
                begin
                    // Hold until the output register is free
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_cur_reg    <= cur_reg;
                        out_tgt_reg    <= tgt_reg;
                        out_tvalid_reg <= tvalid_reg;
                        out_lerr_reg   <= lerr_reg;
                        out_rerr_reg   <= rerr_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.year         = out_cur_reg.year;
    assign rsp.month        = out_cur_reg.month;
    assign rsp.day          = out_cur_reg.day;
    assign rsp.target_year  = out_tgt_reg.year;
    assign rsp.target_month = out_tgt_reg.month;
    assign rsp.target_day   = out_tgt_reg.day;
    assign rsp.target_valid = out_tvalid_reg;
    assign rsp.load_error   = out_lerr_reg;
    assign rsp.range_error  = out_rerr_reg;

endmodule

`default_nettype wire

[tb/tb_calendar_date_stepper.sv]
`timescale 1ns / 1ps
// Self-checking testbench for calendar_date_stepper: directed and random requests.
// Expected dates come from a behavioral calendar walk kept in this file.
// Depends on cds_pkg, cds_req_if, cds_rsp_if and the calendar_date_stepper RTL.

module tb_calendar_date_stepper;
    import cds_pkg::*;

    // Kind code that the block leaves unused: date held, no error flags
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES      = 64;
    localparam int unsigned SLACK_CYCLES     = 20000;

    typedef struct packed {
        logic [1:0]        kind;
        logic [YEAR_W-1:0] year;
        logic [6:0]        month;
        logic [6:0]        day;
    } date_req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  t_year;
        logic [MONTH_W-1:0] t_month;
        logic [DAY_W-1:0]   t_day;
        logic               t_valid;
        logic               ld_err;
        logic               rg_err;
    } date_result_t;

    typedef struct {
        int unsigned y;
        int unsigned m;
        int unsigned d;
    } ymd_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    cds_req_if req_ch();
    cds_rsp_if rsp_ch();

    calendar_date_stepper i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Calendar state mirrored by the predictor, plus the offset register
    ymd_t        cal_now;
    logic [15:0] offset_reg;

    date_req_t    pending_reqs[$];    // requests not yet handed to the driver
    date_result_t expected_dates[$];  // predicted results, oldest first

    int unsigned     queued_cnt   = 0;
    int unsigned     accepted_cnt = 0;
    int unsigned     mismatch_cnt = 0;
    longint unsigned work_budget  = 0;
    longint unsigned cycle_cnt    = 0;

    bit          calm           = 1'b0;  // phase with no idling on either side
    bit          long_hold_arm  = 1'b0;
    bit          long_hold_done;
    int unsigned hold_left;
    int unsigned req_gap;
    int unsigned rsp_stall;
    date_req_t   drv_item;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Advance one day; report 0 and hold the date at Dec 31 of the last year
    function automatic bit day_forward(inout ymd_t c);
        if (c.d < days_in_month(c.y, c.m))
        begin
            c.d++;
            return 1'b1;
        end
        if (c.m < 12)
        begin
            c.m++;
            c.d = 1;
            return 1'b1;
        end
        if (c.y >= YEAR_MAX)
            return 1'b0;
        c.y++;
        c.m = 1;
        c.d = 1;
        return 1'b1;
    endfunction

    // Go back one day; report 0 and hold the date at Jan 1 of year 0
    function automatic bit day_backward(inout ymd_t c);
        if (c.d > 1)
        begin
            c.d--;
            return 1'b1;
        end
        if (c.m > 1)
        begin
            c.m--;
            c.d = days_in_month(c.y, c.m);
            return 1'b1;
        end
        if (c.y == 0)
            return 1'b0;
        c.y--;
        c.m = 12;
        c.d = 31;
        return 1'b1;
    endfunction

    // Number of single-day moves from the current date to the target.
    // A positive offset counts today as day one.
    function automatic int unsigned walk_days(input logic [15:0] ofs);
        if (ofs == 16'd0)
            return 0;
        if (ofs[15])
            return 32'h10000 - ofs;
        return ofs - 1;
    endfunction

    // Apply one request to the mirrored date and work out its result
    function automatic date_result_t predict_date_step(input date_req_t rq);
        ymd_t         cur;
        ymd_t         tgt;
        date_result_t res;
        int unsigned  steps;
        bit           ld_err;
        bit           rg_err;
        bit           t_ok;
        cur    = cal_now;
        ld_err = 1'b0;
        rg_err = 1'b0;
        case (rq.kind)
            KIND_LOAD:
            begin
                if (rq.year <= YEAR_MAX && rq.month >= 1 && rq.month <= 12 &&
                    rq.day >= 1 && rq.day <= days_in_month(rq.year, rq.month))
                begin
                    cur.y = rq.year;
                    cur.m = rq.month;
                    cur.d = rq.day;
                end
                else
                    ld_err = 1'b1;
            end
            KIND_NEXT: rg_err = !day_forward(cur);
            KIND_PREV: rg_err = !day_backward(cur);
            default:   ;
        endcase
        cal_now = cur;

        // Walk the target one day at a time, stopping at the range boundary
        tgt   = cur;
        t_ok  = (offset_reg != 16'd0);
        steps = walk_days(offset_reg);
        for (int unsigned i = 0; i < steps; i++)
        begin
            if (offset_reg[15])
            begin
                if (!day_backward(tgt))
                begin
                    t_ok = 1'b0;
                    break;
                end
            end
            else if (!day_forward(tgt))
            begin
                t_ok = 1'b0;
                break;
            end
        end

        res.year    = YEAR_W'(cur.y);
        res.month   = MONTH_W'(cur.m);
        res.day     = DAY_W'(cur.d);
        res.t_year  = YEAR_W'(tgt.y);
        res.t_month = MONTH_W'(tgt.m);
        res.t_day   = DAY_W'(tgt.d);
        res.t_valid = t_ok;
        res.ld_err  = ld_err;
        res.rg_err  = rg_err;
        return res;
    endfunction

    // Idle cycles before the next transaction on either side
    function automatic int unsigned draw_gap();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic void check_field(input string fname, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            mismatch_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: present queued requests, predict on acceptance
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.kind       <= KIND_LOAD;
            req_ch.load_year  <= '0;
            req_ch.load_month <= '0;
            req_ch.load_day   <= '0;
            req_gap           <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_dates.push_back(predict_date_step(drv_item));
                accepted_cnt <= accepted_cnt + 1;
            end
            // Hold a request that has not been taken yet; otherwise idle or
            // present the next one
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_gap != 0)
                begin
                    req_ch.valid <= 1'b0;
                    req_gap      <= req_gap - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    drv_item = pending_reqs.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.kind       <= drv_item.kind;
                    req_ch.load_year  <= drv_item.year;
                    req_ch.load_month <= drv_item.month;
                    req_ch.load_day   <= drv_item.day;
                    req_gap           <= draw_gap();
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : result_check
        int unsigned  stall_next;
        date_result_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    <= 0;
        end
        else
        begin
            stall_next = rsp_stall;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_dates.size() == 0)
                begin
                    $error("result transaction with no request outstanding");
                    mismatch_cnt++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    check_field("year",         want.year,    rsp_ch.year);
                    check_field("month",        want.month,   rsp_ch.month);
                    check_field("day",          want.day,     rsp_ch.day);
                    check_field("target_year",  want.t_year,  rsp_ch.target_year);
                    check_field("target_month", want.t_month, rsp_ch.target_month);
                    check_field("target_day",   want.t_day,   rsp_ch.target_day);
                    check_field("target_valid", want.t_valid, rsp_ch.target_valid);
                    check_field("load_error",   want.ld_err,  rsp_ch.load_error);
                    check_field("range_error",  want.rg_err,  rsp_ch.range_error);
                end
                stall_next = draw_gap();
            end
            // Count a stall down only while a result is actually waiting
            if (hold_left != 0)
                rsp_ch.ready <= 1'b0;
            else if (stall_next != 0)
            begin
                rsp_ch.ready <= 1'b0;
                if (rsp_ch.valid)
                    stall_next--;
            end
            else
                rsp_ch.ready <= 1'b1;
            rsp_stall <= stall_next;
        end
    end

    // Long back-pressure stretch, armed once by the stimulus so the block
    // fills up and stalls its request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (long_hold_arm && !long_hold_done)
        begin
            hold_left      <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end
    end

    // Watchdog: the budget grows with every queued request by its walk length
    // plus the longest idle on both sides, then is taken four times over
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 4 * work_budget + SLACK_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_request(input logic [1:0] kind,
                                 input int unsigned y, input int unsigned m,
                                 input int unsigned d);
        date_req_t rq;
        rq.kind  = kind;
        rq.year  = YEAR_W'(y);
        rq.month = 7'(m);
        rq.day   = 7'(d);
        pending_reqs.push_back(rq);
        queued_cnt++;
        work_budget += walk_days(offset_reg) + 40;
    endtask

    // Wait until every queued request is taken and every result is back
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (accepted_cnt != queued_cnt || expected_dates.size() != 0);
    endtask

    task automatic write_day_offset(input logic [15:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        offset_reg   = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Legal date, biased toward both ends of the year range and month ends
    function automatic ymd_t pick_valid_date();
        ymd_t        c;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            c.y = $urandom_range(0, 3);
        else if (sel < 4)
            c.y = $urandom_range(YEAR_MAX - 3, YEAR_MAX);
        else if (sel == 4)
            c.y = 100 * $urandom_range(15, 30);
        else
            c.y = $urandom_range(0, YEAR_MAX);
        c.m = $urandom_range(1, 12);
        sel = $urandom_range(0, 9);
        if (sel < 3)
            c.d = days_in_month(c.y, c.m);
        else if (sel < 5)
            c.d = 1;
        else
            c.d = $urandom_range(1, days_in_month(c.y, c.m));
        return c;
    endfunction

    task automatic queue_random_request();
        ymd_t        c;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        c   = pick_valid_date();
        if (sel < 30)
            queue_request(KIND_LOAD, c.y, c.m, c.d);
        else if (sel < 42)
        begin
            // Refused loads: each way a date can be out of bounds
            case ($urandom_range(0, 4))
                0: c.y = $urandom_range(YEAR_MAX + 1, 16383);
                1: c.m = 0;
                2: c.m = $urandom_range(13, 127);
                3: c.d = $urandom_range(0, 1) ? 0
                         : $urandom_range(days_in_month(c.y, c.m) + 1, 127);
                default:
                begin
                    c.y = 4 * $urandom_range(0, 2499) + $urandom_range(1, 3);
                    c.m = 2;
                    c.d = 29;
                end
            endcase
            queue_request(KIND_LOAD, c.y, c.m, c.d);
        end
        else
        begin
            // Load fields carry noise here; the block ignores them
            c.y = $urandom_range(0, 16383);
            c.m = $urandom_range(0, 127);
            c.d = $urandom_range(0, 127);
            if (sel < 68)
                queue_request(KIND_NEXT, c.y, c.m, c.d);
            else if (sel < 94)
                queue_request(KIND_PREV, c.y, c.m, c.d);
            else
                queue_request(KIND_NONE, c.y, c.m, c.d);
        end
    endtask

    // Load a date next to a month, year or range boundary, then step across it
    task automatic queue_date_run();
        ymd_t        c;
        bit          fwd;
        int unsigned steps;
        fwd = $urandom_range(0, 1);
        c.y = $urandom_range(0, YEAR_MAX);
        case ($urandom_range(0, 5))
            0:
            begin
                c.m = 12;
                c.d = 31;
            end
            1:
            begin
                c.m = 1;
                c.d = 1;
            end
            2:
            begin
                c.y = 4 * $urandom_range(0, 2499);
                c.m = 2;
                c.d = days_in_month(c.y, 2);
            end
            3:
            begin
                c.m = $urandom_range(1, 12);
                c.d = days_in_month(c.y, c.m);
            end
            4:
            begin
                c.y = YEAR_MAX;
                c.m = 12;
                c.d = $urandom_range(28, 31);
                fwd = 1'b1;
            end
            default:
            begin
                c.y = 0;
                c.m = 1;
                c.d = $urandom_range(1, 4);
                fwd = 1'b0;
            end
        endcase
        queue_request(KIND_LOAD, c.y, c.m, c.d);
        steps = $urandom_range(2, 6);
        repeat (steps)
        begin
            // Mostly keep direction; now and then turn back
            if (fwd ^ ($urandom_range(0, 7) == 0))
                queue_request(KIND_NEXT, $urandom_range(0, 16383), 0, 0);
            else
                queue_request(KIND_PREV, 0, $urandom_range(0, 127), $urandom_range(0, 127));
        end
    endtask

    task automatic queue_random_batch(input int unsigned count);
        int unsigned start;
        start = queued_cnt;
        while (queued_cnt - start < count)
        begin
            if ($urandom_range(0, 9) < 3)
                queue_date_run();
            else
                queue_random_request();
        end
    endtask

    initial
    begin : stimulus
        int plan[$];
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        cal_now.y         = 2000;
        cal_now.m         = 1;
        cal_now.d         = 1;
        offset_reg        = 16'd0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pass with the offset still at its reset value of zero, so
        // every target repeats the current date with target_valid low
        queue_request(KIND_NEXT, 16383, 127, 127);   // load fields ignored
        queue_request(KIND_PREV, 0, 0, 0);
        queue_request(KIND_LOAD, 2000, 2, 29);       // leap by the 400 rule
        queue_request(KIND_NEXT, 0, 0, 0);
        queue_request(KIND_PREV, 0, 0, 0);
        queue_request(KIND_LOAD, 1900, 2, 29);       // century, not leap
        queue_request(KIND_LOAD, 2023, 2, 29);
        queue_request(KIND_LOAD, 2024, 2, 29);
        queue_request(KIND_LOAD, 0, 2, 29);          // year zero is leap
        queue_request(KIND_LOAD, 0, 1, 1);
        queue_request(KIND_PREV, 0, 0, 0);           // bottom of range, held
        queue_request(KIND_LOAD, YEAR_MAX, 12, 31);
        queue_request(KIND_NEXT, 0, 0, 0);           // top of range, held
        queue_request(KIND_LOAD, YEAR_MAX + 1, 1, 1);
        queue_request(KIND_LOAD, 16383, 127, 127);
        queue_request(KIND_LOAD, 2023, 0, 0);
        queue_request(KIND_LOAD, 2023, 13, 1);
        queue_request(KIND_LOAD, 2023, 4, 31);
        queue_request(KIND_LOAD, 2023, 1, 0);
        queue_request(KIND_LOAD, 2023, 12, 31);
        queue_request(KIND_NEXT, 0, 0, 0);           // year rollover
        queue_request(KIND_PREV, 0, 0, 0);
        queue_request(KIND_NONE, 8191, 85, 42);      // unused kind
        queue_request(KIND_LOAD, 2023, 6, 30);

        // Offset settings, extremes near the end with few requests since each
        // of those walks about 32k days
        plan = '{1, -1, 2, 59, -60, 366, -366, 1461, -1000, 32767, -32768, -2, 0};
        foreach (plan[p])
        begin
            wait_quiet();
            write_day_offset(16'(plan[p]));
            calm = (p % 4 == 1) || (plan[p] == 59);
            if (plan[p] == 59)
                long_hold_arm = 1'b1;
            if (plan[p] == 2 || plan[p] == -1)
            begin
                // Targets that fall off either end of the year range
                queue_request(KIND_LOAD, YEAR_MAX, 12, 31);
                queue_request(KIND_LOAD, 0, 1, 1);
            end
            queue_random_batch((plan[p] >= 32767 || plan[p] <= -32768) ? 2 : 4);
        end

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/cds_pkg.sv
hw/rtl/cds_req_if.sv
hw/rtl/cds_rsp_if.sv
hw/rtl/cds_step.sv
hw/rtl/calendar_date_stepper.sv
tb/tb_calendar_date_stepper.sv
